// ----- design/kad_pkg.sv -----
// Shared types and constants of the KISS deframer and AX.25 header decoder.
package kad_pkg;

  // Frame limit and digipeater chain limit.
  localparam int MAX_FRAME     = 1024;
  localparam int MAX_REPEATERS = 8;

  // Widths.
  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int POS_W  = 11;
  localparam int DIGI_W = 4;
  localparam int END_W  = CNT_W + 8;

  // Queue between the KISS front end and the header back end.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // KISS special bytes.
  localparam logic [7:0] B_FEND  = 8'hC0;
  localparam logic [7:0] B_FESC  = 8'hDB;
  localparam logic [7:0] B_TFEND = 8'hDC;
  localparam logic [7:0] B_TFESC = 8'hDD;

  // AX.25 header layout.
  localparam int POS_DEST_LAST = 7;
  localparam int POS_SRC_LAST  = 14;
  localparam int POS_CTRL      = 15;
  localparam int DIGI_LEN      = 7;

  // Frame classes.
  localparam logic [2:0] CLS_I     = 3'd0;
  localparam logic [2:0] CLS_S     = 3'd1;
  localparam logic [2:0] CLS_U     = 3'd2;
  localparam logic [2:0] CLS_NDATA = 3'd3;
  localparam logic [2:0] CLS_SHORT = 3'd4;

  // Command/response codes.
  localparam logic [1:0] CR_NONE = 2'd0;
  localparam logic [1:0] CR_CMD  = 2'd1;
  localparam logic [1:0] CR_RESP = 2'd2;

  // S frame control codes (low nibble) and subtypes.
  localparam logic [3:0] SC_RR   = 4'h1;
  localparam logic [3:0] SC_RNR  = 4'h5;
  localparam logic [3:0] SC_REJ  = 4'h9;
  localparam logic [3:0] SC_SREJ = 4'hD;
  localparam logic [3:0] SUB_RR    = 4'd0;
  localparam logic [3:0] SUB_RNR   = 4'd1;
  localparam logic [3:0] SUB_REJ   = 4'd2;
  localparam logic [3:0] SUB_SREJ  = 4'd3;
  localparam logic [3:0] SUB_S_UNK = 4'd4;

  // U frame control codes (P/F masked off) and subtypes.
  localparam logic [7:0] U_PF_MASK = 8'hEF;
  localparam logic [7:0] UC_SABME  = 8'h6F;
  localparam logic [7:0] UC_SABM   = 8'h2F;
  localparam logic [7:0] UC_DISC   = 8'h43;
  localparam logic [7:0] UC_DM     = 8'h0F;
  localparam logic [7:0] UC_UA     = 8'h63;
  localparam logic [7:0] UC_FRMR   = 8'h87;
  localparam logic [7:0] UC_UI     = 8'h03;
  localparam logic [7:0] UC_XID    = 8'hAF;
  localparam logic [7:0] UC_TEST   = 8'hE3;
  localparam logic [3:0] SUB_SABME = 4'd0;
  localparam logic [3:0] SUB_SABM  = 4'd1;
  localparam logic [3:0] SUB_DISC  = 4'd2;
  localparam logic [3:0] SUB_DM    = 4'd3;
  localparam logic [3:0] SUB_UA    = 4'd4;
  localparam logic [3:0] SUB_FRMR  = 4'd5;
  localparam logic [3:0] SUB_UI    = 4'd6;
  localparam logic [3:0] SUB_XID   = 4'd7;
  localparam logic [3:0] SUB_TEST  = 4'd8;
  localparam logic [3:0] SUB_U_UNK = 4'd9;

  // One unescaped event from the front end: a frame byte or a frame close.
  typedef struct packed {
    logic       eof;
    logic [7:0] value;
  } tok_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Result payload, first member in the highest bits.
  typedef struct packed {
    logic              overflow;
    logic [DIGI_W-1:0] digi_count;
    logic [3:0]        sub_type;
    logic [2:0]        recv_seq;
    logic [2:0]        send_seq;
    logic              poll_final;
    logic [1:0]        cmd_resp;
    logic [2:0]        frame_class;
    logic [7:0]        kiss_type;
    logic [POS_W-1:0]  position;
    logic [7:0]        byte_value;
  } res_t;

endpackage

// ----- design/kad_front.sv -----
// KISS front end: frame delimiting and unescaping into a token stream.
module kad_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    byte_in,
  input  kad_pkg::qstat_t q_stat,
  output logic          push,
  output kad_pkg::tok_t push_tok
);

  logic in_frame_r, in_frame_nxt;
  logic esc_r, esc_nxt;
  logic take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    esc_nxt        = esc_r;
    push           = 1'b0;
    push_tok.eof   = 1'b0;
    push_tok.value = byte_in;
    if (take) begin
      if (!in_frame_r) begin
        if (byte_in == kad_pkg::B_FEND) begin
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
        end
      end else begin
        case (byte_in)
          kad_pkg::B_FEND: begin
            // A pending escape is dropped with the frame close.
            push         = 1'b1;
            push_tok.eof = 1'b1;
            in_frame_nxt = 1'b0;
            esc_nxt      = 1'b0;
          end
          kad_pkg::B_FESC: begin
            esc_nxt = 1'b1;
          end
          kad_pkg::B_TFEND: begin
            push           = 1'b1;
            push_tok.value = esc_r ? kad_pkg::B_FEND : kad_pkg::B_TFEND;
            esc_nxt        = 1'b0;
          end
          kad_pkg::B_TFESC: begin
            push           = 1'b1;
            push_tok.value = esc_r ? kad_pkg::B_FESC : kad_pkg::B_TFESC;
            esc_nxt        = 1'b0;
          end
          default: begin
            push    = 1'b1;
            esc_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
    end
  end

endmodule

// ----- design/kad_queue.sv -----
// Small token queue between the front end and the back end.
module kad_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  kad_pkg::tok_t   push_tok,
  input  logic            pop,
  output kad_pkg::tok_t   pop_tok,
  output kad_pkg::qstat_t q_stat
);

  kad_pkg::tok_t                 mem_r [kad_pkg::QDEPTH];
  logic [kad_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [kad_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [kad_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (cnt_r == kad_pkg::QCNT_W'(kad_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_tok      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == kad_pkg::QPTR_W'(kad_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == kad_pkg::QPTR_W'(kad_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/kad_back.sv -----
// Header back end: byte positions, AX.25 header tracking, result register.
module kad_back (
  input  logic            clk,
  input  logic            rst_n,
  input  kad_pkg::qstat_t q_stat,
  input  kad_pkg::tok_t   pop_tok,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output kad_pkg::res_t   out_res
);

  localparam int CW = kad_pkg::CNT_W;
  localparam int EW = kad_pkg::END_W;
  localparam int DW = kad_pkg::DIGI_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    type_r, type_nxt;
  logic          dest_c_r, dest_c_nxt;
  logic          src_c_r, src_c_nxt;
  logic          addr_done_r, addr_done_nxt;
  logic [DW-1:0] rpt_r, rpt_nxt;
  logic [EW-1:0] digi_end_r, digi_end_nxt;
  logic [CW-1:0] ctrl_pos_r, ctrl_pos_nxt;
  logic [7:0]    ctrl_r, ctrl_nxt;
  logic          ctrl_seen_r, ctrl_seen_nxt;
  logic          ovf_r, ovf_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  kad_pkg::res_t out_res_r, out_res_nxt;

  kad_pkg::res_t desc;
  logic [DW-1:0] rpt_inc;
  logic [7:0]    b;
  logic [CW-1:0] p;

  // First digipeater field ends at byte 21.
  localparam logic [EW-1:0] DIGI_END0 =
    EW'(kad_pkg::POS_CTRL + kad_pkg::DIGI_LEN - 1);

  assign pop       = !q_stat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_res   = out_res_r;
  assign b         = pop_tok.value;
  assign p         = cnt_r;
  assign rpt_inc   = rpt_r + 1'b1;

  // Descriptor from the header state of the frame being closed.
  always_comb begin
    desc            = '0;
    desc.position   = kad_pkg::POS_W'(cnt_r);
    desc.kiss_type  = type_r;
    desc.overflow   = ovf_r;
    if (type_r != 8'h00) begin
      desc.frame_class = kad_pkg::CLS_NDATA;
    end else if (!ctrl_seen_r) begin
      desc.frame_class = kad_pkg::CLS_SHORT;
      desc.digi_count  = rpt_r;
    end else begin
      desc.digi_count = rpt_r;
      if (dest_c_r && !src_c_r) begin
        desc.cmd_resp = kad_pkg::CR_CMD;
      end else if (!dest_c_r && src_c_r) begin
        desc.cmd_resp = kad_pkg::CR_RESP;
      end
      if (dest_c_r != src_c_r) begin
        desc.poll_final = ctrl_r[4];
      end
      if (!ctrl_r[0]) begin
        desc.frame_class = kad_pkg::CLS_I;
        desc.send_seq    = ctrl_r[3:1];
        desc.recv_seq    = ctrl_r[7:5];
      end else if (!ctrl_r[1]) begin
        desc.frame_class = kad_pkg::CLS_S;
        desc.recv_seq    = ctrl_r[7:5];
        case (ctrl_r[3:0])
          kad_pkg::SC_RR:   desc.sub_type = kad_pkg::SUB_RR;
          kad_pkg::SC_RNR:  desc.sub_type = kad_pkg::SUB_RNR;
          kad_pkg::SC_REJ:  desc.sub_type = kad_pkg::SUB_REJ;
          kad_pkg::SC_SREJ: desc.sub_type = kad_pkg::SUB_SREJ;
          default:          desc.sub_type = kad_pkg::SUB_S_UNK;
        endcase
      end else begin
        desc.frame_class = kad_pkg::CLS_U;
        case (ctrl_r & kad_pkg::U_PF_MASK)
          kad_pkg::UC_SABME: desc.sub_type = kad_pkg::SUB_SABME;
          kad_pkg::UC_SABM:  desc.sub_type = kad_pkg::SUB_SABM;
          kad_pkg::UC_DISC:  desc.sub_type = kad_pkg::SUB_DISC;
          kad_pkg::UC_DM:    desc.sub_type = kad_pkg::SUB_DM;
          kad_pkg::UC_UA:    desc.sub_type = kad_pkg::SUB_UA;
          kad_pkg::UC_FRMR:  desc.sub_type = kad_pkg::SUB_FRMR;
          kad_pkg::UC_UI:    desc.sub_type = kad_pkg::SUB_UI;
          kad_pkg::UC_XID:   desc.sub_type = kad_pkg::SUB_XID;
          kad_pkg::UC_TEST:  desc.sub_type = kad_pkg::SUB_TEST;
          default:           desc.sub_type = kad_pkg::SUB_U_UNK;
        endcase
      end
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    type_nxt      = type_r;
    dest_c_nxt    = dest_c_r;
    src_c_nxt     = src_c_r;
    addr_done_nxt = addr_done_r;
    rpt_nxt       = rpt_r;
    digi_end_nxt  = digi_end_r;
    ctrl_pos_nxt  = ctrl_pos_r;
    ctrl_nxt      = ctrl_r;
    ctrl_seen_nxt = ctrl_seen_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_res_nxt   = out_res_r;

    if (pop) begin
      if (pop_tok.eof) begin
        if (cnt_r != '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_res_nxt   = desc;
        end
        cnt_nxt       = '0;
        type_nxt      = '0;
        dest_c_nxt    = 1'b0;
        src_c_nxt     = 1'b0;
        addr_done_nxt = 1'b0;
        rpt_nxt       = '0;
        digi_end_nxt  = DIGI_END0;
        ctrl_pos_nxt  = '0;
        ctrl_nxt      = '0;
        ctrl_seen_nxt = 1'b0;
        ovf_nxt       = 1'b0;
      end else if (cnt_r >= CW'(kad_pkg::MAX_FRAME)) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (p == '0) begin
          type_nxt = b;
        end
        if (p == CW'(kad_pkg::POS_DEST_LAST)) begin
          dest_c_nxt = b[7];
        end
        if (p == CW'(kad_pkg::POS_SRC_LAST)) begin
          src_c_nxt = b[7];
          if (b[0] || (kad_pkg::MAX_REPEATERS == 0)) begin
            addr_done_nxt = 1'b1;
            ctrl_pos_nxt  = CW'(kad_pkg::POS_CTRL);
          end
        end else if ((p > CW'(kad_pkg::POS_SRC_LAST)) && !addr_done_r &&
                     (EW'(p) == digi_end_r)) begin
          // Last byte of a digipeater field.
          rpt_nxt      = rpt_inc;
          digi_end_nxt = digi_end_r + EW'(kad_pkg::DIGI_LEN);
          if (b[0] || (rpt_inc >= DW'(kad_pkg::MAX_REPEATERS))) begin
            addr_done_nxt = 1'b1;
            ctrl_pos_nxt  = p + 1'b1;
          end
        end else if (addr_done_r && !ctrl_seen_r && (p == ctrl_pos_r)) begin
          ctrl_nxt      = b;
          ctrl_seen_nxt = 1'b1;
        end
        out_valid_nxt        = 1'b1;
        out_kind_nxt         = 1'b0;
        out_res_nxt          = '0;
        out_res_nxt.byte_value = b;
        out_res_nxt.position = kad_pkg::POS_W'(p);
        out_res_nxt.kiss_type = type_nxt;
        out_res_nxt.overflow = ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      type_r      <= '0;
      dest_c_r    <= 1'b0;
      src_c_r     <= 1'b0;
      addr_done_r <= 1'b0;
      rpt_r       <= '0;
      digi_end_r  <= DIGI_END0;
      ctrl_pos_r  <= '0;
      ctrl_r      <= '0;
      ctrl_seen_r <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      type_r      <= type_nxt;
      dest_c_r    <= dest_c_nxt;
      src_c_r     <= src_c_nxt;
      addr_done_r <= addr_done_nxt;
      rpt_r       <= rpt_nxt;
      digi_end_r  <= digi_end_nxt;
      ctrl_pos_r  <= ctrl_pos_nxt;
      ctrl_r      <= ctrl_nxt;
      ctrl_seen_r <= ctrl_seen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/kiss_ax25_frame_decoder.sv -----
// Top level of the KISS deframer with AX.25 header decoder.
//
//   channel  direction  payload
//   in_*     request in   tdata: byte_in
//   out_*    result out   tlast: kind; tdata: decoded byte or frame descriptor
//
// One raw byte is taken per cycle while the token queue is not full. The front
// end unescapes it without a register and writes it into a two-entry token queue
// at the accepting edge; the header back end then pops the queue head and loads
// it into the result register, which offers the result.
// Reset clears frame state and both handshakes; no clearing pass is needed.
// When out_tready is low with a result offered, the result register holds, the back
// end stops, and in_tready falls once the queue is full.
module kiss_ax25_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // kind: high for the end-of-frame descriptor
  output logic [47:0] out_tdata   // [7:0] byte_value, [18:8] position,
                                  // [26:19] kiss_type, [29:27] frame_class,
                                  // [31:30] cmd_resp, [32] poll_final,
                                  // [35:33] send_seq, [38:36] recv_seq,
                                  // [42:39] sub_type, [46:43] digi_count,
                                  // [47] overflow
);

  kad_pkg::qstat_t q_stat;
  kad_pkg::tok_t   push_tok;
  kad_pkg::tok_t   pop_tok;
  kad_pkg::res_t   out_res;
  logic            push;
  logic            pop;

  kad_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .byte_in  (in_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_tok (push_tok)
  );

  kad_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .q_stat   (q_stat)
  );

  kad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_tok   (pop_tok),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tlast),
    .out_res   (out_res)
  );

  assign out_tdata = out_res;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the KISS deframer and AX.25 header decoder.
`timescale 1ns / 1ps

module testbench;
  import kad_pkg::*;

  localparam int RAND_ITEMS     = 580;
  localparam int COVER_FRAMES   = 15;
  localparam int NO_IDLE_FIRST  = 6;
  localparam int NO_IDLE_LAST   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT       = 10;

  typedef struct packed {
    logic kind;
    res_t r;
  } decoded_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_t;

  typedef struct {
    logic [7:0] raw;
    chk_t       how;
    decoded_t   want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tlast;
  logic [47:0] out_tdata;

  // Row bookkeeping travels with in_tdata so the input monitor sees the request it accepts.
  chk_t        row_how = CHK_MODEL;
  decoded_t    row_want = '0;

  decoded_t    decoded_q[$];
  row_t        dir_tab[$];
  int          n_errors = 0;
  int          n_bytes = 0;
  int          stuck_cycles = 0;
  bit          idle_on = 1'b1;

  // Decoder state as the stream is expected to leave it.
  logic        fr_open, esc_pend, dst_c, src_c, addr_done, ctrl_seen, fr_ovf;
  int unsigned fr_len, n_digi, ctrl_pos;
  logic [7:0]  fr_type, ctrl_byte;

  kiss_ax25_frame_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic void clear_frame_state();
    esc_pend  = 1'b0;
    fr_len    = 0;
    fr_type   = 8'h00;
    dst_c     = 1'b0;
    src_c     = 1'b0;
    addr_done = 1'b0;
    n_digi    = 0;
    ctrl_pos  = 0;
    ctrl_byte = 8'h00;
    ctrl_seen = 1'b0;
    fr_ovf    = 1'b0;
  endfunction

  function automatic void track_header(int unsigned p, logic [7:0] b);
    if (p == 0) fr_type = b;
    if (p == POS_DEST_LAST) dst_c = b[7];
    if (p == POS_SRC_LAST) begin
      src_c = b[7];
      if (b[0] || MAX_REPEATERS == 0) begin
        addr_done = 1'b1;
        ctrl_pos  = POS_CTRL;
      end
    end else if (p > POS_SRC_LAST && !addr_done &&
                 p == POS_CTRL + DIGI_LEN * n_digi + DIGI_LEN - 1) begin
      n_digi++;
      if (b[0] || n_digi >= MAX_REPEATERS) begin
        addr_done = 1'b1;
        ctrl_pos  = p + 1;
      end
    end else if (addr_done && !ctrl_seen && p == ctrl_pos) begin
      ctrl_byte = b;
      ctrl_seen = 1'b1;
    end
  endfunction

  function automatic decoded_t describe_frame();
    decoded_t   d;
    logic [7:0] c;
    d = '0;
    c = ctrl_byte;
    d.kind       = 1'b1;
    d.r.position = fr_len[POS_W-1:0];
    d.r.kiss_type = fr_type;
    d.r.overflow = fr_ovf;
    if (fr_type != 8'h00) begin
      d.r.frame_class = CLS_NDATA;
    end else if (!ctrl_seen) begin
      d.r.frame_class = CLS_SHORT;
      d.r.digi_count  = n_digi[DIGI_W-1:0];
    end else begin
      d.r.digi_count = n_digi[DIGI_W-1:0];
      if (dst_c && !src_c) d.r.cmd_resp = CR_CMD;
      if (!dst_c && src_c) d.r.cmd_resp = CR_RESP;
      if (d.r.cmd_resp != CR_NONE) d.r.poll_final = c[4];
      if (!c[0]) begin
        d.r.frame_class = CLS_I;
        d.r.send_seq    = c[3:1];
        d.r.recv_seq    = c[7:5];
      end else if (!c[1]) begin
        d.r.frame_class = CLS_S;
        d.r.recv_seq    = c[7:5];
        case (c[3:0])
          SC_RR:   d.r.sub_type = SUB_RR;
          SC_RNR:  d.r.sub_type = SUB_RNR;
          SC_REJ:  d.r.sub_type = SUB_REJ;
          SC_SREJ: d.r.sub_type = SUB_SREJ;
          default: d.r.sub_type = SUB_S_UNK;
        endcase
      end else begin
        d.r.frame_class = CLS_U;
        case (c & U_PF_MASK)
          UC_SABME: d.r.sub_type = SUB_SABME;
          UC_SABM:  d.r.sub_type = SUB_SABM;
          UC_DISC:  d.r.sub_type = SUB_DISC;
          UC_DM:    d.r.sub_type = SUB_DM;
          UC_UA:    d.r.sub_type = SUB_UA;
          UC_FRMR:  d.r.sub_type = SUB_FRMR;
          UC_UI:    d.r.sub_type = SUB_UI;
          UC_XID:   d.r.sub_type = SUB_XID;
          UC_TEST:  d.r.sub_type = SUB_TEST;
          default:  d.r.sub_type = SUB_U_UNK;
        endcase
      end
    end
    return d;
  endfunction

  // Advances the decoder state by one raw byte; at most one result comes out.
  function automatic void kiss_decode_byte(input logic [7:0] b, output bit produced,
                                           output decoded_t d);
    logic [7:0]  v;
    int unsigned p;
    produced = 1'b0;
    d = '0;
    if (!fr_open) begin
      if (b == B_FEND) begin
        fr_open = 1'b1;
        clear_frame_state();
      end
    end else if (b == B_FEND) begin
      if (fr_len > 0) begin
        d = describe_frame();
        produced = 1'b1;
      end
      fr_open = 1'b0;
      clear_frame_state();
    end else if (b == B_FESC) begin
      esc_pend = 1'b1;
    end else begin
      v = b;
      if (esc_pend && b == B_TFEND) v = B_FEND;
      if (esc_pend && b == B_TFESC) v = B_FESC;
      esc_pend = 1'b0;
      if (fr_len >= MAX_FRAME) begin
        fr_ovf = 1'b1;
      end else begin
        p = fr_len;
        fr_len++;
        track_header(p, v);
        d.r.byte_value = v;
        d.r.position   = p[POS_W-1:0];
        d.r.kiss_type  = fr_type;
        d.r.overflow   = fr_ovf;
        produced = 1'b1;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ERROR: %s expected %0h, got %0h", $time, name, want_v, got_v);
      n_errors++;
    end
  endtask

  // Input side: every accepted byte moves the predicted decoder state.
  always @(posedge clk) begin : in_mon
    bit       produced;
    decoded_t d;
    if (rst_n && in_tvalid && in_tready) begin
      kiss_decode_byte(in_tdata, produced, d);
      if (row_how == CHK_GIVEN) decoded_q.push_back(row_want);
      else if (row_how == CHK_MODEL && produced) decoded_q.push_back(d);
    end
  end

  always @(posedge clk) begin : out_mon
    decoded_t want;
    res_t     got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (decoded_q.size() == 0) begin
        $display("%0t ERROR: unexpected result, expected none, got tlast %b tdata %h",
                 $time, out_tlast, out_tdata);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_tlast));
        check_field("byte_value", 16'(want.r.byte_value), 16'(got.byte_value));
        check_field("position", 16'(want.r.position), 16'(got.position));
        check_field("kiss_type", 16'(want.r.kiss_type), 16'(got.kiss_type));
        check_field("frame_class", 16'(want.r.frame_class), 16'(got.frame_class));
        check_field("cmd_resp", 16'(want.r.cmd_resp), 16'(got.cmd_resp));
        check_field("poll_final", 16'(want.r.poll_final), 16'(got.poll_final));
        check_field("send_seq", 16'(want.r.send_seq), 16'(got.send_seq));
        check_field("recv_seq", 16'(want.r.recv_seq), 16'(got.recv_seq));
        check_field("sub_type", 16'(want.r.sub_type), 16'(got.sub_type));
        check_field("digi_count", 16'(want.r.digi_count), 16'(got.digi_count));
        check_field("overflow", 16'(want.r.overflow), 16'(got.overflow));
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ERROR: no request or result moved for %0d cycles", $time, stuck_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void add_row(input logic [7:0] raw, input chk_t how, input logic kind,
                                  input logic [7:0] val, input int pos,
                                  input logic [7:0] kt, input logic [2:0] cls);
    row_t row;
    row.raw  = raw;
    row.how  = how;
    row.want = '0;
    row.want.kind          = kind;
    row.want.r.byte_value  = val;
    row.want.r.position    = pos[POS_W-1:0];
    row.want.r.kiss_type   = kt;
    row.want.r.frame_class = cls;
    dir_tab.push_back(row);
  endfunction

  task automatic send_byte(input logic [7:0] raw, input chk_t how, input decoded_t want);
    if (idle_on && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    row_how   <= how;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_raw(input logic [7:0] raw);
    send_byte(raw, CHK_MODEL, '0);
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // Builds one frame body, mostly a well-formed AX.25 header, and sends it KISS-escaped.
  task automatic send_frame(input int frame_no);
    logic [7:0] body[$];
    logic [7:0] ctrl;
    logic [7:0] b;
    int         n_rep, k, r, cut;
    bit         structured;
    body = {};
    structured = (frame_no < COVER_FRAMES) || ($urandom_range(0, 7) != 0);
    if (!structured) begin
      repeat ($urandom_range(1, 20)) body.push_back(8'($urandom));
    end else begin
      body.push_back((frame_no >= COVER_FRAMES && $urandom_range(0, 9) == 0) ?
                     8'($urandom_range(1, 255)) : 8'h00);
      for (k = 1; k <= POS_SRC_LAST; k++) body.push_back(8'($urandom));
      n_rep = ($urandom_range(0, 2) == 0) ? $urandom_range(1, MAX_REPEATERS) : 0;
      body[POS_SRC_LAST][0] = (n_rep == 0);
      for (r = 0; r < n_rep; r++) begin
        for (k = 0; k < DIGI_LEN; k++) begin
          b = 8'($urandom);
          if (k == DIGI_LEN - 1) b[0] = (r == n_rep - 1);
          body.push_back(b);
        end
      end
      // A full chain ends the address even when the extension bit says more follow.
      if (n_rep == MAX_REPEATERS && $urandom_range(0, 1) == 1) body[body.size() - 1][0] = 1'b0;
      ctrl = 8'($urandom);
      if (frame_no < 4) begin
        case (frame_no)
          0: ctrl[3:0] = SC_RR;
          1: ctrl[3:0] = SC_RNR;
          2: ctrl[3:0] = SC_REJ;
          default: ctrl[3:0] = SC_SREJ;
        endcase
      end else if (frame_no < 14) begin
        case (frame_no)
          4: b = UC_SABME;
          5: b = UC_SABM;
          6: b = UC_DISC;
          7: b = UC_DM;
          8: b = UC_UA;
          9: b = UC_FRMR;
          10: b = UC_UI;
          11: b = UC_XID;
          12: b = UC_TEST;
          default: b = 8'h0B;
        endcase
        ctrl = b | (ctrl & ~U_PF_MASK);
      end else if (frame_no == 14) begin
        ctrl[0] = 1'b0;
      end
      body.push_back(ctrl);
      repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
      if (frame_no >= COVER_FRAMES && $urandom_range(0, 9) == 0) begin
        // Cut the frame off before its control byte.
        cut = $urandom_range(1, body.size() - 2 - (body.size() > 16 ? 12 : 0));
        while (body.size() > cut) void'(body.pop_back());
      end
    end

    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == B_FEND) b = 8'h00;
        send_raw(b);
      end
    end
    send_raw(B_FEND);
    if ($urandom_range(0, 14) == 0) begin
      send_raw(B_FEND);
      send_raw(B_FEND);
    end
    foreach (body[i]) begin
      if (body[i] == B_FEND) begin
        send_raw(B_FESC);
        send_raw(B_TFEND);
      end else if (body[i] == B_FESC) begin
        if ($urandom_range(0, 9) == 0) send_raw(B_FESC);
        send_raw(B_FESC);
        send_raw(B_TFESC);
      end else begin
        if ($urandom_range(0, 29) == 0) send_raw(B_FESC);
        send_raw(body[i]);
      end
    end
    if ($urandom_range(0, 14) == 0) send_raw(B_FESC);
    send_raw(B_FEND);
  endtask

  initial begin : stim
    int frame_no;
    fr_open = 1'b0;
    clear_frame_state();

    add_row(8'h55,   CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_TFEND, CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FEND,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FEND,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FEND,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(8'hFF,   CHK_GIVEN, 1'b0, 8'hFF,   0, 8'hFF, CLS_I);
    add_row(B_FESC,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_TFEND, CHK_GIVEN, 1'b0, B_FEND,  1, 8'hFF, CLS_I);
    add_row(B_FESC,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FESC,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_TFESC, CHK_GIVEN, 1'b0, B_FESC,  2, 8'hFF, CLS_I);
    add_row(B_FESC,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(8'h41,   CHK_GIVEN, 1'b0, 8'h41,   3, 8'hFF, CLS_I);
    add_row(B_TFEND, CHK_GIVEN, 1'b0, B_TFEND, 4, 8'hFF, CLS_I);
    add_row(B_TFESC, CHK_GIVEN, 1'b0, B_TFESC, 5, 8'hFF, CLS_I);
    add_row(B_FESC,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FEND,  CHK_GIVEN, 1'b1, 8'h00,   6, 8'hFF, CLS_NDATA);
    add_row(B_FEND,  CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(8'h00,   CHK_GIVEN, 1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(8'h7E,   CHK_MODEL, 1'b0, 8'h00,   0, 8'h00, CLS_I);
    add_row(B_FEND,  CHK_GIVEN, 1'b1, 8'h00,   2, 8'h00, CLS_SHORT);
    add_row(8'h00,   CHK_NONE,  1'b0, 8'h00,   0, 8'h00, CLS_I);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_byte(dir_tab[i].raw, dir_tab[i].how, dir_tab[i].want);
    drain_results();

    frame_no = 0;
    while (n_bytes < dir_tab.size() + RAND_ITEMS) begin
      idle_on = !(frame_no >= NO_IDLE_FIRST && frame_no <= NO_IDLE_LAST);
      send_frame(frame_no);
      if (frame_no % 5 == 4) drain_results();
      frame_no++;
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- kiss_ax25_frame_decoder.f -----
design/kad_pkg.sv
design/kad_front.sv
design/kad_queue.sv
design/kad_back.sv
design/kiss_ax25_frame_decoder.sv
sim/testbench.sv
